FILE: hdl/pixel_rate_spike_encoder_macros.svh
// assertion macros shared by the encoder modules
`ifndef PIXEL_RATE_SPIKE_ENCODER_MACROS_SVH
`define PIXEL_RATE_SPIKE_ENCODER_MACROS_SVH

// condition holds at every edge out of reset
`define PRSE_ASSERT_ALW(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define PRSE_ASSERT_IMP(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

FILE: hdl/prse_pkg.sv
package prse_pkg;

	localparam int PIXEL_COUNT = 1024;
	localparam int MAX_STEPS  = 64;

	localparam int IDX_W   = 10;
	localparam int PIX_W   = 8;
	localparam int FACT_W  = 20;
	localparam int STEPS_W = 7;
	localparam int INC_W   = 28;
	localparam int ACC_W   = 32;
	localparam int FRAC_W  = 16;
	localparam int MASK_W  = 64;
	localparam int ADDR_W  = 10;
	localparam int NSTG    = MAX_STEPS + 1;
	localparam int MASK_SHIFT = MASK_W - MAX_STEPS;

	localparam logic [ACC_W-1:0]   ONE_Q16      = ACC_W'(32'h0001_0000);
	localparam logic [ADDR_W-1:0]  LAST_ADDR    = ADDR_W'(PIXEL_COUNT - 1);
	localparam logic [STEPS_W-1:0] STEP_LIM_MAX = STEPS_W'(MAX_STEPS);

	localparam logic [FACT_W-1:0]  FACTOR_RST   = FACT_W'(257);
	localparam logic [STEPS_W-1:0] ACTIVE_RST   = STEPS_W'(64);
	localparam logic [STEPS_W-1:0] FRAME_RST    = STEPS_W'(64);

	typedef enum logic [1:0] {
		CFG_INCR_FACTOR     = 2'd0,
		CFG_ACTIVE_STEPS    = 2'd1,
		CFG_STEPS_PER_FRAME = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic              in_range;
		logic [IDX_W-1:0]  idx;
		logic [INC_W-1:0]  inc;
		logic [ACC_W-1:0]  acc;
		logic              sat;
		logic [MASK_W-1:0] mask;
	} item_t;

	function automatic logic [INC_W-1:0] calc_inc(input logic [FACT_W-1:0] factor,
		input logic [PIX_W-1:0] pix);
		return INC_W'(factor) * INC_W'(pix);
	endfunction

	function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
		return 32'(idx) < 32'(PIXEL_COUNT);
	endfunction

	function automatic logic step_on(input int k, input logic [STEPS_W-1:0] lim);
		return STEPS_W'(k) < lim;
	endfunction

endpackage

FILE: hdl/pixel_rate_spike_encoder.sv
// Integrate-and-fire rate encoder: each pixel transaction adds increment_factor * pixel_value
// to that pixel's Q16.16 accumulator once per active step and returns the 64-bit spike mask.
// Pipeline: one accumulator read stage, 64 step stages (one add, clamp and fire per stage) and
// an output register. One pixel can enter every cycle as long as the output is not stalled and
// its index differs from those of the pixels still in the 65 internal stages; a pixel whose
// index matches one in flight is held until that one has written its accumulator back. A stall
// on the output freezes the whole pipeline. After reset the accumulator memory is cleared one
// entry per cycle, and in_stall stays high during that clear pass; configuration writes are
// taken during that time.
`include "pixel_rate_spike_encoder_macros.svh"

module pixel_rate_spike_encoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [1:0]                   cfg_index,
	input  logic [prse_pkg::FACT_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [prse_pkg::IDX_W-1:0]   pixel_index,
	input  logic [prse_pkg::PIX_W-1:0]   pixel_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [prse_pkg::IDX_W-1:0]   pixel_index_out,
	output logic [prse_pkg::MASK_W-1:0]  spike_mask,
	output logic                         saturated
);

	logic [prse_pkg::FACT_W-1:0]  incr_factor_q;
	logic [prse_pkg::STEPS_W-1:0] active_steps_q;
	logic [prse_pkg::STEPS_W-1:0] steps_per_frame_q;
	logic [prse_pkg::STEPS_W-1:0] frame_lim;
	logic [prse_pkg::STEPS_W-1:0] step_lim;
	logic [prse_pkg::STEPS_W-1:0] step_lim_q;

	logic                         adv;
	logic                         accept;
	logic                         hit;
	logic                         clr_busy;
	logic [prse_pkg::ACC_W-1:0]   rd_data;

	logic                         vld_s1;
	logic [prse_pkg::IDX_W-1:0]   idx_s1;
	logic [prse_pkg::INC_W-1:0]   inc_s1;
	logic                         in_range_s1;

	logic [prse_pkg::NSTG-1:0]                      chain_vld;
	prse_pkg::item_t                                chain_item [prse_pkg::NSTG];
	logic [prse_pkg::NSTG-1:0][prse_pkg::IDX_W-1:0] chain_idx;
	logic [prse_pkg::MAX_STEPS-1:0]                 step_en;
	prse_pkg::item_t                                last_item;

	logic                         wr_en;
	logic                         out_vld_q;
	logic [prse_pkg::IDX_W-1:0]   out_idx_q;
	logic [prse_pkg::MASK_W-1:0]  out_mask_q;
	logic                         out_sat_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			incr_factor_q     <= prse_pkg::FACTOR_RST;
			active_steps_q    <= prse_pkg::ACTIVE_RST;
			steps_per_frame_q <= prse_pkg::FRAME_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				prse_pkg::CFG_INCR_FACTOR:     incr_factor_q     <= cfg_data;
				prse_pkg::CFG_ACTIVE_STEPS:    active_steps_q    <= cfg_data[prse_pkg::STEPS_W-1:0];
				prse_pkg::CFG_STEPS_PER_FRAME: steps_per_frame_q <= cfg_data[prse_pkg::STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	assign frame_lim = (steps_per_frame_q > prse_pkg::STEP_LIM_MAX) ? prse_pkg::STEP_LIM_MAX
		: steps_per_frame_q;
	assign step_lim  = (active_steps_q < frame_lim) ? active_steps_q : frame_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_lim_q <= prse_pkg::STEP_LIM_MAX;
		end else begin
			step_lim_q <= step_lim;
		end
	end

	// global advance, input handshake
	assign adv      = ~out_vld_q | ~out_stall;
	assign in_stall = clr_busy | ~adv | hit;
	assign accept   = in_valid & ~in_stall;

	prse_hazard u_hazard (
		.idx     (pixel_index),
		.stg_vld (chain_vld),
		.stg_idx (chain_idx),
		.hit     (hit)
	);

	prse_acc_mem u_acc_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adv),
		.rd_addr (pixel_index[prse_pkg::ADDR_W-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (last_item.idx[prse_pkg::ADDR_W-1:0]),
		.wr_data (last_item.acc),
		.busy    (clr_busy)
	);

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1      <= pixel_index;
			inc_s1      <= prse_pkg::calc_inc(incr_factor_q, pixel_value);
			in_range_s1 <= prse_pkg::idx_in_range(pixel_index);
		end
	end

	assign chain_vld[0]           = vld_s1;
	assign chain_item[0].in_range = in_range_s1;
	assign chain_item[0].idx      = idx_s1;
	assign chain_item[0].inc      = inc_s1;
	assign chain_item[0].acc      = rd_data;
	assign chain_item[0].sat      = 1'b0;
	assign chain_item[0].mask     = '0;

	// step stages
	for (genvar k = 0; k < prse_pkg::MAX_STEPS; k++) begin : g_step
		assign step_en[k] = prse_pkg::step_on(k, step_lim_q);

		prse_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.step_en  (step_en[k]),
			.in_vld   (chain_vld[k]),
			.in_item  (chain_item[k]),
			.out_vld  (chain_vld[k+1]),
			.out_item (chain_item[k+1])
		);
	end

	for (genvar k = 0; k < prse_pkg::NSTG; k++) begin : g_idx
		assign chain_idx[k] = chain_item[k].idx;
	end

	// write back and output register
	assign last_item = chain_item[prse_pkg::MAX_STEPS];
	assign wr_en     = adv & chain_vld[prse_pkg::MAX_STEPS] & last_item.in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= chain_vld[prse_pkg::MAX_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_idx_q  <= last_item.idx;
			out_mask_q <= last_item.mask >> prse_pkg::MASK_SHIFT;
			out_sat_q  <= last_item.sat;
		end
	end

	assign out_valid       = out_vld_q;
	assign pixel_index_out = out_idx_q;
	assign spike_mask      = out_mask_q;
	assign saturated       = out_sat_q;

	`PRSE_ASSERT_IMP(a_no_accept_in_clear, in_valid && !in_stall, !clr_busy, "accept in clear")
	`PRSE_ASSERT_ALW(a_step_lim_bound, step_lim_q <= prse_pkg::STEP_LIM_MAX, "step limit too big")
	`PRSE_ASSERT_IMP(a_mask_in_limit, out_vld_q, (out_mask_q >> step_lim_q) == '0, "late spike")

endmodule

FILE: hdl/prse_step.sv
module prse_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            step_en,
	input  logic            in_vld,
	input  prse_pkg::item_t in_item,
	output logic            out_vld,
	output prse_pkg::item_t out_item
);

	logic [prse_pkg::ACC_W:0]   sum;
	logic [prse_pkg::ACC_W-1:0] acc_sat;
	logic [prse_pkg::ACC_W-1:0] acc_new;
	logic                       fire;
	logic                       active;
	prse_pkg::item_t            nxt;
	logic                       vld_s1;
	prse_pkg::item_t            item_s1;

	assign sum = {1'b0, in_item.acc}
		+ {{(prse_pkg::ACC_W + 1 - prse_pkg::INC_W){1'b0}}, in_item.inc};
	assign acc_sat = sum[prse_pkg::ACC_W] ? '1 : sum[prse_pkg::ACC_W-1:0];
	assign fire    = |acc_sat[prse_pkg::ACC_W-1:prse_pkg::FRAC_W];
	assign acc_new = fire ? acc_sat - prse_pkg::ONE_Q16 : acc_sat;
	assign active  = in_vld & in_item.in_range & step_en;

	always_comb begin
		nxt = in_item;
		// this step's bit enters at the top, earlier steps move down
		nxt.mask = {active & fire, in_item.mask[prse_pkg::MASK_W-1:1]};
		if (active) begin
			nxt.acc = acc_new;
			nxt.sat = in_item.sat | sum[prse_pkg::ACC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= nxt;
		end
	end

	assign out_vld  = vld_s1;
	assign out_item = item_s1;

endmodule

FILE: hdl/prse_hazard.sv
module prse_hazard (
	input  logic [prse_pkg::IDX_W-1:0]                   idx,
	input  logic [prse_pkg::NSTG-1:0]                    stg_vld,
	input  logic [prse_pkg::NSTG-1:0][prse_pkg::IDX_W-1:0] stg_idx,
	output logic                                         hit
);

	logic [prse_pkg::NSTG-1:0] match;

	always_comb begin
		for (int k = 0; k < prse_pkg::NSTG; k++) begin
			match[k] = stg_vld[k] & (stg_idx[k] == idx);
		end
	end

	assign hit = |match;

endmodule

FILE: hdl/prse_acc_mem.sv
`include "pixel_rate_spike_encoder_macros.svh"

module prse_acc_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [prse_pkg::ADDR_W-1:0] rd_addr,
	output logic [prse_pkg::ACC_W-1:0]  rd_data,
	input  logic                        wr_en,
	input  logic [prse_pkg::ADDR_W-1:0] wr_addr,
	input  logic [prse_pkg::ACC_W-1:0]  wr_data,
	output logic                        busy
);

	logic [prse_pkg::ACC_W-1:0]  mem [prse_pkg::PIXEL_COUNT];
	logic [prse_pkg::ACC_W-1:0]  rd_data_q;
	logic [prse_pkg::ADDR_W-1:0] clr_cnt_q;
	logic                        busy_q;
	logic                        we;
	logic [prse_pkg::ADDR_W-1:0] wa;
	logic [prse_pkg::ACC_W-1:0]  wd;

	// clear pass after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_cnt_q <= '0;
		end else if (busy_q) begin
			clr_cnt_q <= clr_cnt_q + prse_pkg::ADDR_W'(1);
			if (clr_cnt_q == prse_pkg::LAST_ADDR) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign we = busy_q | wr_en;
	assign wa = busy_q ? clr_cnt_q : wr_addr;
	assign wd = busy_q ? '0 : wr_data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

	`PRSE_ASSERT_IMP(a_no_write_in_clear, wr_en, !busy_q, "accumulator write during clear pass")

endmodule

FILE: test/pixel_rate_spike_encoder_test.sv
module pixel_rate_spike_encoder_test;

	import prse_pkg::*;

	localparam logic [1:0]        CFG_UNUSED     = 2'd3;
	localparam logic [FACT_W-1:0] GAIN_MAX       = '1;
	localparam logic [FACT_W-1:0] GAIN_ONE       = FACT_W'(32'h1_0000);
	localparam int                WATCHDOG_LIMIT = 4000;
	localparam int                LONG_HOLD      = 300;
	localparam int                HOT_COUNT      = 16;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [PIX_W-1:0] pix;
	} pixel_txn_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [MASK_W-1:0] mask;
		logic              sat;
	} spike_txn_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en = 1'b0;
	logic [1:0]          cfg_index = CFG_INCR_FACTOR;
	logic [FACT_W-1:0]   cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [IDX_W-1:0]    pixel_index = '0;
	logic [PIX_W-1:0]    pixel_value = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [IDX_W-1:0]    pixel_index_out;
	logic [MASK_W-1:0]   spike_mask;
	logic                saturated;

	pixel_rate_spike_encoder i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.pixel_index     (pixel_index),
		.pixel_value     (pixel_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pixel_index_out (pixel_index_out),
		.spike_mask      (spike_mask),
		.saturated       (saturated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the encoder state
	logic [ACC_W-1:0]   pixel_acc [PIXEL_COUNT];
	logic [FACT_W-1:0]  gain_q;
	logic [STEPS_W-1:0] active_q;
	logic [STEPS_W-1:0] frame_q;

	pixel_txn_t  pixel_queue [$];
	spike_txn_t  pending_masks [$];

	int          idle_pct = 0;
	int          stall_pct = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	logic        want_long_hold = 1'b0;
	logic        long_hold_done = 1'b0;
	int unsigned mismatches = 0;
	int unsigned quiet = 0;

	function automatic spike_txn_t encode_pixel(input pixel_txn_t p);
		spike_txn_t       r;
		logic [ACC_W-1:0] acc;
		logic [ACC_W-1:0] inc;
		logic [ACC_W:0]   sum;
		int unsigned      lim;
		r.idx = p.idx;
		r.mask = '0;
		r.sat = 1'b0;
		if (int'(p.idx) < PIXEL_COUNT) begin
			lim = (int'(frame_q) > MAX_STEPS) ? MAX_STEPS : int'(frame_q);
			if (int'(active_q) < lim)
				lim = active_q;
			inc = ACC_W'(gain_q) * ACC_W'(p.pix);
			acc = pixel_acc[p.idx];
			for (int s = 0; s < lim; s++) begin
				sum = {1'b0, acc} + {1'b0, inc};
				if (sum[ACC_W]) begin
					sum = {1'b0, {ACC_W{1'b1}}};
					r.sat = 1'b1;
				end
				acc = sum[ACC_W-1:0];
				if (acc >= ONE_Q16) begin
					r.mask[s] = 1'b1;
					acc = acc - ONE_Q16;
				end
			end
			pixel_acc[p.idx] = acc;
		end
		return r;
	endfunction

	// pixel driver
	always @(posedge clk) begin
		pixel_txn_t p;
		logic       took;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			took = in_valid && !in_stall;
			if (took) begin
				p.idx = pixel_index;
				p.pix = pixel_value;
				pending_masks = {pending_masks, encode_pixel(p)};
				void'(pixel_queue.pop_front());
				if (idle_pct != 0 && $urandom_range(99) < idle_pct)
					send_gap = $urandom_range(13, 1);
			end
			if (in_valid && !took) begin
				// stalled transaction stays on the port
			end else if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pixel_queue.size() != 0) begin
				in_valid <= 1'b1;
				pixel_index <= pixel_queue[0].idx;
				pixel_value <= pixel_queue[0].pix;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// mask monitor
	always @(posedge clk) begin
		spike_txn_t got;
		spike_txn_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got.idx = pixel_index_out;
				got.mask = spike_mask;
				got.sat = saturated;
				if (pending_masks.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: idx %0d mask %h sat %b",
							got.idx, got.mask, got.sat);
				end else begin
					want = pending_masks.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: idx %0d/%0d mask %h/%h sat %b/%b (exp/act)",
								want.idx, got.idx, want.mask, got.mask, want.sat, got.sat);
					end
				end
			end
			if (want_long_hold && !long_hold_done) begin
				hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				stall_left = $urandom_range(13, 1) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet == WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic add_pixel(input int idx, input int pix);
		pixel_txn_t p;
		p.idx = IDX_W'(idx);
		p.pix = PIX_W'(pix);
		pixel_queue = {pixel_queue, p};
	endtask

	task automatic drain();
		while (pixel_queue.size() != 0 || pending_masks.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [FACT_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
	endtask

	task automatic program_encoder(input logic [FACT_W-1:0] gain,
		input logic [STEPS_W-1:0] active, input logic [STEPS_W-1:0] frame);
		drain();
		write_reg(CFG_INCR_FACTOR, gain);
		write_reg(CFG_ACTIVE_STEPS, FACT_W'(active));
		write_reg(CFG_STEPS_PER_FRAME, FACT_W'(frame));
		// unmapped index must leave the registers alone
		write_reg(CFG_UNUSED, FACT_W'($urandom));
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		gain_q = gain;
		active_q = active;
		frame_q = frame;
	endtask

	initial begin
		logic [IDX_W-1:0]   hot [HOT_COUNT];
		logic [FACT_W-1:0]  gain;
		logic [STEPS_W-1:0] active;
		logic [STEPS_W-1:0] frame;
		int                 pix;
		arst_n = 1'b0;
		gain_q = FACTOR_RST;
		active_q = ACTIVE_RST;
		frame_q = FRAME_RST;
		foreach (pixel_acc[i])
			pixel_acc[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, same-pixel back to back, step limits
		idle_pct = 20;
		stall_pct = 20;
		add_pixel(0, 0);
		add_pixel(PIXEL_COUNT - 1, 255);
		add_pixel(0, 255);
		add_pixel(0, 255);
		add_pixel(0, 255);
		add_pixel(10'h2AA, 8'h55);
		add_pixel(10'h155, 8'hAA);
		add_pixel(1, 1);
		program_encoder(GAIN_MAX, 7'd64, 7'd64);
		add_pixel(7, 255);
		add_pixel(7, 255);
		add_pixel(8, 1);
		add_pixel(PIXEL_COUNT - 1, 128);
		program_encoder(GAIN_ONE, 7'd10, 7'd64);
		add_pixel(9, 255);
		add_pixel(9, 3);
		program_encoder(FACT_W'(32'h1_8000), 7'd64, 7'd20);
		add_pixel(10, 200);
		program_encoder(GAIN_ONE, 7'd0, 7'd64);
		add_pixel(11, 255);
		program_encoder(GAIN_ONE, 7'd100, 7'd0);
		add_pixel(11, 255);
		program_encoder(FACT_W'(32'h8000), 7'd127, 7'd127);
		add_pixel(12, 77);
		add_pixel(12, 255);
		program_encoder('0, 7'd64, 7'd64);
		add_pixel(13, 255);

		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(3))
				0: gain = GAIN_MAX;
				1: gain = FACT_W'($urandom_range(32'h1_FFFF));
				2: gain = FACT_W'($urandom);
				default: gain = FACT_W'($urandom_range(32'h3000));
			endcase
			active = ($urandom_range(3) == 0) ? STEPS_W'($urandom_range(127))
				: STEPS_W'($urandom_range(64, 1));
			frame = ($urandom_range(3) == 0) ? STEPS_W'($urandom_range(127))
				: STEPS_W'($urandom_range(64, 1));
			program_encoder(gain, active, frame);
			idle_pct = (ph % 3 == 2) ? 0 : $urandom_range(40, 5);
			stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(40, 5);
			foreach (hot[i])
				hot[i] = IDX_W'($urandom);
			for (int n = 0; n < 190; n++) begin
				case ($urandom_range(7))
					0: pix = 0;
					1: pix = 255;
					default: pix = $urandom_range(255);
				endcase
				if ($urandom_range(1) == 0)
					add_pixel(hot[$urandom_range(HOT_COUNT - 1)], pix);
				else
					add_pixel($urandom_range(PIXEL_COUNT - 1), pix);
			end
			if (ph == 1)
				want_long_hold = 1'b1;
		end

		// closing stretch at full rate
		program_encoder(FACTOR_RST, ACTIVE_RST, FRAME_RST);
		idle_pct = 0;
		stall_pct = 0;
		for (int n = 0; n < 150; n++)
			add_pixel($urandom_range(PIXEL_COUNT - 1), $urandom_range(255));
		drain();
		repeat (80) @(posedge clk);

		if (mismatches == 0 && pending_masks.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
